### sv/sldnp_pkg.sv
// sldnp_pkg: shared types and constants of the serial line decimal number parser
// used by the controller, the datapath and the top level
`timescale 1ns / 1ps

package sldnp_pkg;

   typedef enum logic [3:0] {
      PH_START,
      PH_LEADZ,
      PH_INT,
      PH_DOT,
      PH_FRAC,
      PH_ESIGN,
      PH_EDIG,
      PH_DONE
   } phase_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_LOAD,
      ST_MUL,
      ST_DIV,
      ST_FINISH
   } state_type;

   typedef struct packed {
      logic parse;
      logic load;
      logic mul_step;
      logic div_step;
      logic finish;
   } cmd_type;

   typedef struct packed {
      logic newline;
      logic e_pos;
      logic e_neg;
      logic mul_stop;
      logic div_done;
      logic out_free;
   } status_type;

   localparam logic [7:0] CH_NEWLINE = 8'd10;
   localparam logic [7:0] CH_MINUS   = 8'h2D;
   localparam logic [7:0] CH_PLUS    = 8'h2B;
   localparam logic [7:0] CH_DOT     = 8'h2E;
   localparam logic [7:0] CH_ZERO    = 8'h30;
   localparam logic [7:0] CH_NINE    = 8'h39;
   localparam logic [7:0] CH_E_LOW   = 8'h65;
   localparam logic [7:0] CH_E_UP    = 8'h45;

   localparam int MANT_W = 57;
   localparam int ACC_W  = 80;
   localparam int CNT_W  = 9;
   localparam logic [MANT_W-1:0] MANT_CAP = 57'd10000000000000000;
   localparam logic [CNT_W-1:0]  DIV_STEPS_MAX = 9'd40;
   localparam logic [3:0] DIV_SUB_LAST = 4'd9;
   localparam logic [MANT_W-1:0] WHOLE_MUL_LIMIT = 57'h80000000;
   localparam logic [MANT_W-1:0] WHOLE_LIMIT = 57'd32768;
   localparam logic [32:0] POS_LIMIT = 33'h07FFFFFFF;
   localparam logic [32:0] NEG_LIMIT = 33'h080000000;

endpackage

### sv/sldnp_if.sv
// sldnp_req_if / sldnp_rsp_if: valid-ready channels of the parser
// depends on nothing
`timescale 1ns / 1ps

interface sldnp_req_if;
   logic       valid;
   logic       ready;
   logic [7:0] rx_byte;
   modport source (output valid, output rx_byte, input ready);
   modport sink (input valid, input rx_byte, output ready);
endinterface

interface sldnp_rsp_if;
   logic               valid;
   logic               ready;
   logic signed [31:0] value;
   logic               saturated;
   modport source (output valid, output value, output saturated, input ready);
   modport sink (input valid, input value, input saturated, output ready);
endinterface

### sv/sldnp_ctrl.sv
// sldnp_ctrl: controller state machine of the parser
// depends on sldnp_pkg
`timescale 1ns / 1ps

module sldnp_ctrl (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   output logic                 req_ready,
   input  sldnp_pkg::status_type status,
   output sldnp_pkg::cmd_type    cmd
);

   sldnp_pkg::state_type state_ff, state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= sldnp_pkg::ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         sldnp_pkg::ST_IDLE: begin
            if (req_valid && status.newline) state_in = sldnp_pkg::ST_LOAD;
         end
         sldnp_pkg::ST_LOAD: begin
            priority if (status.e_pos) state_in = sldnp_pkg::ST_MUL;
            else if (status.e_neg) state_in = sldnp_pkg::ST_DIV;
            else state_in = sldnp_pkg::ST_FINISH;
         end
         sldnp_pkg::ST_MUL: begin
            if (status.mul_stop) state_in = sldnp_pkg::ST_FINISH;
         end
         sldnp_pkg::ST_DIV: begin
            if (status.div_done) state_in = sldnp_pkg::ST_FINISH;
         end
         sldnp_pkg::ST_FINISH: begin
            if (status.out_free) state_in = sldnp_pkg::ST_IDLE;
         end
         default: state_in = sldnp_pkg::ST_IDLE;
      endcase
   end

   always_comb begin
      cmd = '0;
      req_ready = 1'b0;
      unique case (state_ff)
         sldnp_pkg::ST_IDLE: begin
            req_ready = 1'b1;
            cmd.parse = req_valid && !status.newline;
         end
         sldnp_pkg::ST_LOAD: cmd.load = 1'b1;
         sldnp_pkg::ST_MUL: cmd.mul_step = 1'b1;
         sldnp_pkg::ST_DIV: cmd.div_step = !status.div_done;
         sldnp_pkg::ST_FINISH: cmd.finish = status.out_free;
         default: cmd = '0;
      endcase
   end

endmodule

### sv/sldnp_dpath.sv
// sldnp_dpath: line parser registers, scaling accumulator and result register
// depends on sldnp_pkg
`timescale 1ns / 1ps

module sldnp_dpath #(
   parameter int MAX_LINE = 32
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic [7:0]            rx_byte,
   input  sldnp_pkg::cmd_type     cmd,
   output sldnp_pkg::status_type  status,
   output logic                  rsp_valid,
   input  logic                  rsp_ready,
   output logic signed [31:0]    rsp_value,
   output logic                  rsp_saturated
);

   localparam int CC_W = (MAX_LINE > 2) ? $clog2(MAX_LINE) : 1;
   localparam logic [CC_W-1:0] CC_LAST = CC_W'(MAX_LINE - 1);

   sldnp_pkg::phase_type phase_ff, phase_in;
   logic                        neg_ff, neg_in;
   logic [sldnp_pkg::MANT_W-1:0] mant_ff, mant_in;
   logic signed [8:0]           dshift_ff, dshift_in;
   logic [7:0]                  exp_ff, exp_in;
   logic                        eneg_ff, eneg_in;
   logic [CC_W-1:0]             cc_ff;
   logic [sldnp_pkg::ACC_W-1:0]  acc_ff;
   logic [3:0]                  rem_ff;
   logic [3:0]                  sub_ff;
   logic [sldnp_pkg::CNT_W-1:0]  cnt_ff;
   logic                        sat_ff;
   logic                        out_valid_ff;
   logic signed [31:0]          out_value_ff;
   logic                        out_sat_ff;

   // next parser state for one character
   always_comb begin
      logic dig;
      logic ech;
      logic [3:0] d;
      logic take;
      logic frac;
      logic edig;
      logic [11:0] e_new;
      sldnp_pkg::phase_type ph;
      dig = (rx_byte >= sldnp_pkg::CH_ZERO) && (rx_byte <= sldnp_pkg::CH_NINE);
      ech = (rx_byte == sldnp_pkg::CH_E_LOW) || (rx_byte == sldnp_pkg::CH_E_UP);
      d = dig ? 4'(rx_byte - sldnp_pkg::CH_ZERO) : 4'd0;
      take = 1'b0;
      frac = 1'b0;
      edig = 1'b0;
      e_new = 12'd0;
      phase_in = phase_ff;
      neg_in = neg_ff;
      mant_in = mant_ff;
      dshift_in = dshift_ff;
      exp_in = exp_ff;
      eneg_in = eneg_ff;
      ph = phase_ff;
      if (phase_ff == sldnp_pkg::PH_START) begin
         ph = sldnp_pkg::PH_LEADZ;
         phase_in = sldnp_pkg::PH_LEADZ;
      end
      if (phase_ff == sldnp_pkg::PH_START && rx_byte == sldnp_pkg::CH_MINUS) begin
         neg_in = 1'b1;
      end else begin
         unique case (ph)
            sldnp_pkg::PH_LEADZ: begin
               priority if (rx_byte == sldnp_pkg::CH_ZERO) phase_in = sldnp_pkg::PH_LEADZ;
               else if (dig) begin
                  take = 1'b1;
                  phase_in = sldnp_pkg::PH_INT;
               end else if (rx_byte == sldnp_pkg::CH_DOT) phase_in = sldnp_pkg::PH_DOT;
               else if (ech) phase_in = sldnp_pkg::PH_ESIGN;
               else phase_in = sldnp_pkg::PH_DONE;
            end
            sldnp_pkg::PH_INT: begin
               priority if (dig) take = 1'b1;
               else if (rx_byte == sldnp_pkg::CH_DOT) phase_in = sldnp_pkg::PH_DOT;
               else if (ech) phase_in = sldnp_pkg::PH_ESIGN;
               else phase_in = sldnp_pkg::PH_DONE;
            end
            sldnp_pkg::PH_DOT: begin
               if (dig) begin
                  take = 1'b1;
                  frac = 1'b1;
                  phase_in = sldnp_pkg::PH_FRAC;
               end else begin
                  phase_in = sldnp_pkg::PH_DONE;
               end
            end
            sldnp_pkg::PH_FRAC: begin
               priority if (dig) begin
                  take = 1'b1;
                  frac = 1'b1;
               end else if (ech) phase_in = sldnp_pkg::PH_ESIGN;
               else phase_in = sldnp_pkg::PH_DONE;
            end
            sldnp_pkg::PH_ESIGN: begin
               priority if (rx_byte == sldnp_pkg::CH_PLUS) phase_in = sldnp_pkg::PH_EDIG;
               else if (rx_byte == sldnp_pkg::CH_MINUS) begin
                  eneg_in = 1'b1;
                  phase_in = sldnp_pkg::PH_EDIG;
               end else if (dig) begin
                  edig = 1'b1;
                  phase_in = sldnp_pkg::PH_EDIG;
               end else phase_in = sldnp_pkg::PH_DONE;
            end
            sldnp_pkg::PH_EDIG: begin
               if (dig) edig = 1'b1;
               else phase_in = sldnp_pkg::PH_DONE;
            end
            default: phase_in = phase_ff;
         endcase
      end
      if (take) begin
         if (mant_ff < sldnp_pkg::MANT_CAP) begin
            mant_in = (mant_ff << 3) + (mant_ff << 1) + sldnp_pkg::MANT_W'(d);
            if (frac && dshift_ff != -9'sd256) dshift_in = dshift_ff - 9'sd1;
         end else if (!frac && dshift_ff != 9'sd255) begin
            dshift_in = dshift_ff + 9'sd1;
         end
      end
      if (edig) begin
         e_new = ({4'd0, exp_ff} << 3) + ({4'd0, exp_ff} << 1) + {8'd0, d};
         exp_in = (e_new > 12'd255) ? 8'd255 : e_new[7:0];
      end
   end

   // total power of ten
   logic signed [10:0] e_total;
   logic [10:0]        e_abs;
   assign e_total = eneg_ff ? (11'(dshift_ff) - 11'(signed'({1'b0, exp_ff})))
                            : (11'(dshift_ff) + 11'(signed'({1'b0, exp_ff})));
   assign e_abs = e_total[10] ? 11'(-e_total) : 11'(e_total);

   logic [sldnp_pkg::MANT_W-1:0] whole;
   assign whole = acc_ff[72:16];

   // eight restoring steps of a divide by ten
   logic [sldnp_pkg::ACC_W-1:0] div_acc;
   logic [3:0]                 div_rem;
   always_comb begin
      logic [4:0] r;
      logic [3:0] rr;
      logic [7:0] q;
      rr = (sub_ff == 4'd0) ? 4'd0 : rem_ff;
      q = 8'd0;
      for (int k = 0; k < 8; k++) begin
         r = {rr, acc_ff[sldnp_pkg::ACC_W-1-k]};
         if (r >= 5'd10) begin
            q[7-k] = 1'b1;
            r = r - 5'd10;
         end
         rr = r[3:0];
      end
      div_rem = rr;
      div_acc = {acc_ff[sldnp_pkg::ACC_W-9:0], q};
   end

   // final clamp and sign
   logic                fin_sat;
   logic [32:0]         fin_mag;
   always_comb begin
      fin_sat = sat_ff || (whole > sldnp_pkg::WHOLE_LIMIT);
      fin_mag = acc_ff[32:0];
      if (fin_sat) begin
         fin_mag = neg_ff ? sldnp_pkg::NEG_LIMIT : sldnp_pkg::POS_LIMIT;
      end else if (!neg_ff && fin_mag > sldnp_pkg::POS_LIMIT) begin
         fin_mag = sldnp_pkg::POS_LIMIT;
         fin_sat = 1'b1;
      end else if (neg_ff && fin_mag > sldnp_pkg::NEG_LIMIT) begin
         fin_mag = sldnp_pkg::NEG_LIMIT;
         fin_sat = 1'b1;
      end
   end

   logic clear_line;
   assign clear_line = cmd.finish || (cmd.parse && cc_ff == CC_LAST);

   always_ff @(posedge clock) begin
      if (reset || clear_line) begin
         phase_ff <= sldnp_pkg::PH_START;
         neg_ff <= 1'b0;
         mant_ff <= '0;
         dshift_ff <= '0;
         exp_ff <= '0;
         eneg_ff <= 1'b0;
         cc_ff <= '0;
      end else if (cmd.parse) begin
         phase_ff <= phase_in;
         neg_ff <= neg_in;
         mant_ff <= mant_in;
         dshift_ff <= dshift_in;
         exp_ff <= exp_in;
         eneg_ff <= eneg_in;
         cc_ff <= cc_ff + CC_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.load) begin
         acc_ff <= {7'd0, mant_ff, 16'd0};
         sat_ff <= 1'b0;
         sub_ff <= 4'd0;
         if (e_total[10]) begin
            cnt_ff <= (e_abs > 11'(sldnp_pkg::DIV_STEPS_MAX)) ? sldnp_pkg::DIV_STEPS_MAX
                                                             : e_abs[8:0];
         end else begin
            cnt_ff <= e_abs[8:0];
         end
      end else if (cmd.mul_step) begin
         if (cnt_ff != '0 && whole != '0) begin
            if (whole > sldnp_pkg::WHOLE_MUL_LIMIT) begin
               sat_ff <= 1'b1;
            end else begin
               acc_ff <= (acc_ff << 3) + (acc_ff << 1);
               cnt_ff <= cnt_ff - 9'd1;
            end
         end
      end else if (cmd.div_step) begin
         acc_ff <= div_acc;
         rem_ff <= div_rem;
         if (sub_ff == sldnp_pkg::DIV_SUB_LAST) begin
            sub_ff <= 4'd0;
            cnt_ff <= cnt_ff - 9'd1;
         end else begin
            sub_ff <= sub_ff + 4'd1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else if (cmd.finish) begin
         out_valid_ff <= 1'b1;
      end else if (rsp_ready) begin
         out_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.finish) begin
         out_value_ff <= neg_ff ? 32'(-fin_mag) : fin_mag[31:0];
         out_sat_ff <= fin_sat;
      end
   end

   assign status.newline = (rx_byte == sldnp_pkg::CH_NEWLINE);
   assign status.e_pos = !e_total[10] && (e_total != 11'sd0);
   assign status.e_neg = e_total[10];
   assign status.mul_stop = (cnt_ff == '0) || (whole == '0)
                            || (whole > sldnp_pkg::WHOLE_MUL_LIMIT);
   assign status.div_done = (cnt_ff == '0);
   assign status.out_free = !out_valid_ff || rsp_ready;

   assign rsp_valid = out_valid_ff;
   assign rsp_value = out_value_ff;
   assign rsp_saturated = out_sat_ff;

endmodule

### sv/serial_line_decimal_number_parser.sv
// serial_line_decimal_number_parser: top level, parses newline-ended lines to Q16.16
// depends on sldnp_pkg, sldnp_if, sldnp_ctrl, sldnp_dpath
//
// req_if carries one received byte per beat; rsp_if carries value and saturated
// once per newline. A beat is taken when valid and ready are both high.
// Ordinary bytes are parsed as they are taken and give no result.
// A newline starts a conversion: a load step, then multiply-by-ten steps
// (positive exponent) or up to 40 divide-by-ten steps (negative exponent),
// or neither (zero exponent), then a write into the result register. The
// worst case is set by the divide unit, which retires eight quotient bits a cycle.
// req_ready is low during a conversion and high otherwise.
// The result register holds a finished beat while the next line is parsed; the
// conversion of a following newline waits in FINISH until rsp_if is taken.
// Synchronous reset clears the parser, the controller and rsp valid.
//
`timescale 1ns / 1ps

module serial_line_decimal_number_parser #(
   parameter int MAX_LINE = 32
) (
   input  logic          clock,
   input  logic          reset,
   sldnp_req_if.sink     req_if,
   sldnp_rsp_if.source   rsp_if
);

   sldnp_pkg::cmd_type    cmd;
   sldnp_pkg::status_type status;

   sldnp_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_if.valid),
      .req_ready (req_if.ready),
      .status    (status),
      .cmd       (cmd)
   );

   sldnp_dpath #(
      .MAX_LINE (MAX_LINE)
   ) u_dpath (
      .clock         (clock),
      .reset         (reset),
      .rx_byte       (req_if.rx_byte),
      .cmd           (cmd),
      .status        (status),
      .rsp_valid     (rsp_if.valid),
      .rsp_ready     (rsp_if.ready),
      .rsp_value     (rsp_if.value),
      .rsp_saturated (rsp_if.saturated)
   );

endmodule
